// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the lagged correlation RTL
// Each macro expands to one labeled concurrent assertion on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define LPC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle
`define LPC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/lpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants, codes and interface types of the lagged correlation block.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int MAX_LAG_DEF = 64;
	localparam int MAX_SAMPLES = 65536;
	localparam int IDX_W       = 17;
	localparam int WORD_W      = 64;
	localparam int HALF_W      = 32;
	localparam int PROD_W      = 128;
	localparam int TQ_W        = 33;
	localparam int QV_W        = 15;
	localparam int DIV_STEPS   = 32;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_VAR = 2'd1;
	localparam logic [1:0] ST_NO_PAIRS = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// operand selection for the shared multiplier, issued in this order
	typedef enum logic [2:0] {
		MS_MXX  = 3'd0,
		MS_SXSX = 3'd1,
		MS_MYY  = 3'd2,
		MS_SYSY = 3'd3,
		MS_MXY  = 3'd4,
		MS_SXSY = 3'd5,
		MS_VXVY = 3'd6,
		MS_CC   = 3'd7
	} mul_sel_t;

	typedef enum logic [2:0] {
		OP_NONE      = 3'd0,
		OP_MUL       = 3'd1,
		OP_DIV_INIT  = 3'd2,
		OP_DIV_STEP  = 3'd3,
		OP_ROOT_STEP = 3'd4,
		OP_OUT       = 3'd5
	} dp_op_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t sel;
		logic [3:0] bit_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sums_done;
		logic no_pairs;
		logic zero_var;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic signed [32:0] sum_x;
		logic signed [32:0] sum_y;
		logic [46:0]        sum_xx;
		logic [46:0]        sum_yy;
		logic signed [47:0] sum_xy;
		logic [IDX_W-1:0]   pair_count;
		logic               overflow;
	} acc_sums_t;

endpackage

// File: src/lpc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_accum
// Lag pairing through the delay store and the running sums, one pair a cycle while accept is high.
// ----------------------------------------------------------------------------
module lpc_accum import lpc_pkg::*; #(
	parameter int MAX_LAG = MAX_LAG_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              clear,
	input  logic signed [7:0] lag_val,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	input  logic              last_in,
	output acc_sums_t         sums,
	output logic              sums_done
);

	`include "assert_macros.svh"

	localparam int AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
	localparam int DW = $clog2(MAX_LAG + 1);

	logic signed [15:0] store_mem [MAX_LAG];
	logic signed [15:0] rd_q;

	logic [IDX_W-1:0] idx_q;
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_addr;
	logic [8:0]       lag_mag;
	logic [DW-1:0]    lag_dist;
	logic             in_range, ready, lag_pos, lag_zero;

	logic               v_s1, last_s1, old_x_s1, old_y_s1;
	logic signed [15:0] x_s1, y_s1;
	logic signed [15:0] a_pick, b_pick;
	logic               v_s2, last_s2, last_s3;
	logic signed [15:0] a_s2, b_s2;
	logic [30:0]        aa_s2, bb_s2;
	logic signed [31:0] ab_s2;
	logic signed [31:0] aa_full, bb_full;

	acc_sums_t sums_q;

	// clamped lag distance and store addressing
	always_comb begin
		lag_mag  = lag_val[7] ? (9'd0 - {lag_val[7], lag_val}) : {1'b0, lag_val};
		if (32'(lag_mag) > 32'(MAX_LAG))
			lag_dist = DW'(MAX_LAG);
		else
			lag_dist = DW'(lag_mag);
		lag_zero = (lag_val == 8'sd0);
		lag_pos  = !lag_val[7] && !lag_zero;
		in_range = (32'(idx_q) < 32'(MAX_SAMPLES));
		ready    = (32'(idx_q) >= 32'(lag_dist));
		if (32'(wr_ptr_q) >= 32'(lag_dist))
			rd_addr = AW'(32'(wr_ptr_q) - 32'(lag_dist));
		else
			rd_addr = AW'(32'(wr_ptr_q) + 32'(MAX_LAG) - 32'(lag_dist));
	end

	// delay store, registered read
	always_ff @(posedge clk) begin
		if (accept && in_range && !lag_zero)
			store_mem[wr_ptr_q] <= lag_pos ? x_in : y_in;
		if (accept)
			rd_q <= store_mem[rd_addr];
	end

	// series index and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			wr_ptr_q <= '0;
		end else if (clear) begin
			idx_q    <= '0;
			wr_ptr_q <= '0;
		end else if (accept && in_range) begin
			idx_q <= idx_q + 1'b1;
			if (32'(wr_ptr_q) == 32'(MAX_LAG - 1))
				wr_ptr_q <= '0;
			else
				wr_ptr_q <= wr_ptr_q + 1'b1;
		end
	end

	// stage 1: capture pair selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= accept && in_range && (lag_zero || ready);
			last_s1 <= accept && last_in;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= x_in;
			y_s1     <= y_in;
			old_x_s1 <= lag_pos;
			old_y_s1 <= lag_val[7];
		end
	end

	// stage 2: products
	always_comb begin
		a_pick  = old_x_s1 ? rd_q : x_s1;
		b_pick  = old_y_s1 ? rd_q : y_s1;
		aa_full = a_pick * a_pick;
		bb_full = b_pick * b_pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s2  <= a_pick;
		b_s2  <= b_pick;
		aa_s2 <= aa_full[30:0];
		bb_s2 <= bb_full[30:0];
		ab_s2 <= a_pick * b_pick;
	end

	// stage 3: running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else begin
			if (clear) begin
				sums_q <= '0;
			end else begin
				if (accept && !in_range)
					sums_q.overflow <= 1'b1;
				if (v_s2) begin
					sums_q.sum_x      <= sums_q.sum_x + 33'(a_s2);
					sums_q.sum_y      <= sums_q.sum_y + 33'(b_s2);
					sums_q.sum_xx     <= sums_q.sum_xx + 47'(aa_s2);
					sums_q.sum_yy     <= sums_q.sum_yy + 47'(bb_s2);
					sums_q.sum_xy     <= sums_q.sum_xy + 48'(ab_s2);
					sums_q.pair_count <= sums_q.pair_count + 1'b1;
				end
			end
		end
	end

	assign sums      = sums_q;
	assign sums_done = last_s3;

	`LPC_ASSERT(a_idx_bound, 32'(idx_q) <= 32'(MAX_SAMPLES), "sample index past limit")

endmodule

// File: src/lpc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_mul
// 64x64 unsigned multiply over four 32x32 partial products.
// ----------------------------------------------------------------------------
module lpc_mul import lpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	`include "assert_macros.svh"

	logic [WORD_W-1:0] a_q, b_q;
	logic [PROD_W-1:0] acc_q, pp_ext;
	logic [WORD_W-1:0] pp_s1;
	logic [1:0]        sh_s1;
	logic [2:0]        cnt_q;
	logic              busy_q, pp_v_s1, done_q;
	logic [HALF_W-1:0] a_half, b_half;

	// control: four issue slots, then the final add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			pp_v_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pp_v_s1 <= busy_q && (cnt_q != 3'd4);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					cnt_q <= cnt_q + 3'd1;
				end else if (pp_v_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign a_half = cnt_q[1] ? a_q[WORD_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_half = cnt_q[0] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];

	// place partial product by limb weight
	always_comb begin
		case (sh_s1)
			2'd0:    pp_ext = PROD_W'(pp_s1);
			2'd1:    pp_ext = PROD_W'(pp_s1) << HALF_W;
			2'd2:    pp_ext = PROD_W'(pp_s1) << (2 * HALF_W);
			default: pp_ext = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		pp_s1 <= a_half * b_half;
		sh_s1 <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (pp_v_s1) begin
			acc_q <= acc_q + pp_ext;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	`LPC_ASSERT_IMPL(a_no_restart, start, !busy_q, "multiply started while busy")

endmodule

// File: src/lpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_datapath
// Sums, variance and covariance products, quotient and root search, output.
// ----------------------------------------------------------------------------
module lpc_datapath import lpc_pkg::*; #(
	parameter int MAX_LAG = MAX_LAG_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr,
	input  logic signed [7:0]  cfg_data,
	input  logic               in_accept,
	input  logic signed [15:0] x_sample,
	input  logic signed [15:0] y_sample,
	input  logic               last,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] correlation,
	output logic [1:0]         status,
	output logic [16:0]        pairs_used
);

	`include "assert_macros.svh"

	logic signed [7:0] lag_q;
	acc_sums_t         sums;
	logic              sums_done, mul_done, mul_start;
	logic [WORD_W-1:0] op_a, op_b;
	logic [PROD_W-1:0] prod;
	logic [31:0]       sx_mag, sy_mag;
	logic [46:0]       sxy_mag;
	logic              negp, negq;

	mul_sel_t          sel_q;
	logic [WORD_W-1:0] t_q, vx_q, vy_q, cmag_q;
	logic              cneg_q;
	logic [PROD_W-1:0] vv_q, cc_q, rem_q;
	logic [TQ_W-1:0]   tq_q;
	logic [QV_W-1:0]   qv_q;

	logic [PROD_W:0]   r2;
	logic              ge;
	logic [QV_W-1:0]   cand;
	logic [15:0]       todd;
	logic [31:0]       sq;
	logic              no_pairs, zero_var;

	logic              out_valid_q;
	logic signed [15:0] corr_q;
	logic [1:0]        status_q;
	logic [16:0]       pairs_q;

	// lag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lag_q <= '0;
		else if (cfg_wr)
			lag_q <= cfg_data;
	end

	lpc_accum #(.MAX_LAG(MAX_LAG)) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.clear     (cmd.op == OP_OUT),
		.lag_val   (lag_q),
		.x_in      (x_sample),
		.y_in      (y_sample),
		.last_in   (last),
		.sums      (sums),
		.sums_done (sums_done)
	);

	// sign and magnitude of the sums
	always_comb begin
		sx_mag  = sums.sum_x[32] ? 32'(-sums.sum_x) : 32'(sums.sum_x);
		sy_mag  = sums.sum_y[32] ? 32'(-sums.sum_y) : 32'(sums.sum_y);
		sxy_mag = sums.sum_xy[47] ? 47'(-sums.sum_xy) : 47'(sums.sum_xy);
		negp    = sums.sum_xy[47];
		negq    = sums.sum_x[32] ^ sums.sum_y[32];
	end

	// multiplier operand select
	always_comb begin
		case (cmd.sel)
			MS_MXX:  begin op_a = 64'(sums.pair_count); op_b = 64'(sums.sum_xx); end
			MS_SXSX: begin op_a = 64'(sx_mag);          op_b = 64'(sx_mag);      end
			MS_MYY:  begin op_a = 64'(sums.pair_count); op_b = 64'(sums.sum_yy); end
			MS_SYSY: begin op_a = 64'(sy_mag);          op_b = 64'(sy_mag);      end
			MS_MXY:  begin op_a = 64'(sums.pair_count); op_b = 64'(sxy_mag);     end
			MS_SXSY: begin op_a = 64'(sx_mag);          op_b = 64'(sy_mag);      end
			MS_VXVY: begin op_a = vx_q;                 op_b = vy_q;             end
			MS_CC:   begin op_a = cmag_q;               op_b = cmag_q;           end
			default: begin op_a = '0;                   op_b = '0;               end
		endcase
	end

	assign mul_start = (cmd.op == OP_MUL);

	lpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// one quotient bit and one root candidate per step
	always_comb begin
		r2   = {rem_q, 1'b0};
		ge   = (r2 >= {1'b0, vv_q});
		cand = qv_q | (QV_W'(1) << cmd.bit_idx);
		todd = {cand, 1'b0} - 16'd1;
		sq   = todd * todd;
	end

	// product bookkeeping, divide and root
	always_ff @(posedge clk) begin
		if (mul_start)
			sel_q <= cmd.sel;
		if (mul_done) begin
			case (sel_q)
				MS_MXX, MS_MYY, MS_MXY: t_q <= prod[WORD_W-1:0];
				MS_SXSX: vx_q <= t_q - prod[WORD_W-1:0];
				MS_SYSY: vy_q <= t_q - prod[WORD_W-1:0];
				MS_SXSY: begin
					if (negp == negq) begin
						if (t_q >= prod[WORD_W-1:0]) begin
							cmag_q <= t_q - prod[WORD_W-1:0];
							cneg_q <= negp;
						end else begin
							cmag_q <= prod[WORD_W-1:0] - t_q;
							cneg_q <= !negp;
						end
					end else begin
						cmag_q <= t_q + prod[WORD_W-1:0];
						cneg_q <= negp;
					end
				end
				MS_VXVY: vv_q <= prod;
				MS_CC:   cc_q <= prod;
				default: t_q <= t_q;
			endcase
		end
		case (cmd.op)
			OP_DIV_INIT: begin
				qv_q <= '0;
				if (cc_q >= vv_q) begin
					rem_q <= cc_q - vv_q;
					tq_q  <= TQ_W'(1);
				end else begin
					rem_q <= cc_q;
					tq_q  <= '0;
				end
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? PROD_W'(r2 - {1'b0, vv_q}) : PROD_W'(r2);
				tq_q  <= {tq_q[TQ_W-2:0], ge};
			end
			OP_ROOT_STEP: begin
				if ({1'b0, sq} <= tq_q)
					qv_q <= cand;
			end
			default: qv_q <= qv_q;
		endcase
	end

	assign no_pairs = (sums.pair_count == '0);
	assign zero_var = (vx_q == '0) || (vy_q == '0);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_OUT)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			pairs_q <= sums.pair_count;
			if (no_pairs || zero_var)
				corr_q <= '0;
			else if (cneg_q)
				corr_q <= 16'sd0 - $signed({1'b0, qv_q});
			else
				corr_q <= $signed({1'b0, qv_q});
			if (sums.overflow)
				status_q <= ST_OVERFLOW;
			else if (no_pairs)
				status_q <= ST_NO_PAIRS;
			else if (zero_var)
				status_q <= ST_ZERO_VAR;
			else
				status_q <= ST_OK;
		end
	end

	always_comb begin
		stat.mul_done  = mul_done;
		stat.sums_done = sums_done;
		stat.no_pairs  = no_pairs;
		stat.zero_var  = zero_var;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign correlation = corr_q;
	assign status      = status_q;
	assign pairs_used  = pairs_q;

	`LPC_ASSERT_IMPL(a_out_free, cmd.op == OP_OUT, stat.out_free, "result overwritten")
	`LPC_ASSERT_IMPL(a_rem_bound, cmd.op == OP_DIV_STEP, rem_q < vv_q, "remainder not reduced")
	`LPC_ASSERT_IMPL(a_tq_bound, cmd.op == OP_ROOT_STEP, tq_q <= (TQ_W'(1) << DIV_STEPS),
		"ratio above one")

endmodule

// File: src/lpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer: accumulate, drain, product chain, divide, root search, output.
// ----------------------------------------------------------------------------
module lpc_ctrl import lpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_ACCUM = 8'b0000_0001,
		S_DRAIN = 8'b0000_0010,
		S_MUL   = 8'b0000_0100,
		S_MWAIT = 8'b0000_1000,
		S_DIVI  = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_ROOT  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	mul_sel_t   sel_q, sel_d;
	logic [4:0] cnt_q, cnt_d;

	// next state and command
	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cnt_d       = cnt_q;
		cmd.op      = OP_NONE;
		cmd.sel     = sel_q;
		cmd.bit_idx = cnt_q[3:0];
		case (state_q)
			S_ACCUM: begin
				if (in_valid && last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (stat.sums_done) begin
					sel_d   = MS_MXX;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				// variances known once the squares are done
				if (sel_q == MS_MXY && (stat.no_pairs || stat.zero_var)) begin
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_MUL;
					state_d = S_MWAIT;
				end
			end
			S_MWAIT: begin
				if (stat.mul_done) begin
					if (sel_q == MS_CC) begin
						state_d = S_DIVI;
					end else begin
						sel_d   = mul_sel_t'(3'(sel_q) + 3'd1);
						state_d = S_MUL;
					end
				end
			end
			S_DIVI: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					cnt_d   = 5'(QV_W - 1);
					state_d = S_ROOT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_ROOT: begin
				cmd.op = OP_ROOT_STEP;
				if (cnt_q == '0)
					state_d = S_OUT;
				else
					cnt_d = cnt_q - 5'd1;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_ACCUM;
				end
			end
			default: state_d = S_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCUM;
			sel_q   <= MS_MXX;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall = (state_q != S_ACCUM);

endmodule

// File: src/lagged_pearson_correlation.sv
`timescale 1ns / 1ps
// Sequence after the last pair: pipeline drain, up to 8 multiplies on one shared 32x32
//   multiplier, 33 divide steps, 15 root steps.
// Throughput: one sample pair per cycle within a series; after the last pair
//   input stalls until the result is written to the output register.
// Reset: asynchronous, clears sums, index, lag and valids; delay store is not cleared.
// ----------------------------------------------------------------------------
// lagged_pearson_correlation
// Lagged Pearson correlation of two Q1.15 streams, result in Q1.15 per series.
// ----------------------------------------------------------------------------
module lagged_pearson_correlation import lpc_pkg::*; #(
	parameter int MAX_LAG = MAX_LAG_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [7:0]  lag,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] x_sample,
	input  logic signed [15:0] y_sample,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] correlation,
	output logic [1:0]         status,
	output logic [16:0]        pairs_used
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	lpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpc_datapath #(.MAX_LAG(MAX_LAG)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_data    (lag),
		.in_accept   (in_valid && !in_stall),
		.x_sample    (x_sample),
		.y_sample    (y_sample),
		.last        (last),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.correlation (correlation),
		.status      (status),
		.pairs_used  (pairs_used)
	);

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lagged_pearson_correlation. A scoreboard predicts
// each series result from the accepted sample pairs and the current lag, and
// checks the output transfers in order. The stimulus covers directed corner
// series, random series over a set of lags and back-pressure.
// ----------------------------------------------------------------------------
module tb import lpc_pkg::*; ();

	localparam int  MAX_LAG_TB  = 64;
	localparam int  DRAIN_WAIT  = 200;
	localparam int  LONG_HOLD   = 400;
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  RAND_ITEMS  = 500;

	typedef struct {
		logic signed [15:0] corr;
		logic [1:0]         stat;
		logic [16:0]        pairs;
	} corr_result_t;

	// Predicts series results and compares output transfers against them
	class corr_scoreboard;
		logic signed [15:0] delay_mem[MAX_LAG_TB];
		int unsigned        sample_idx;
		int unsigned        pair_cnt;
		longint             sx, sy, sxy;
		longint unsigned    sxx, syy;
		bit                 ovf;
		logic signed [7:0]  lag_reg;
		corr_result_t       expected_q[$];
		int                 errors;

		function new();
			lag_reg = 0;
			errors = 0;
			clear();
		endfunction

		function void clear();
			sample_idx = 0;
			pair_cnt = 0;
			sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
			ovf = 0;
		endfunction

		function void set_lag(logic signed [7:0] v);
			lag_reg = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		function void add_pair(longint a, longint b);
			sx += a;
			sy += b;
			sxx += a * a;
			syy += b * b;
			sxy += a * b;
			pair_cnt++;
		endfunction

		function void note_input(logic signed [15:0] x, logic signed [15:0] y, logic lst);
			int                 el;
			int unsigned        d;
			logic signed [15:0] old;
			bit [255:0]         m_w, ax, ay, axy, vx, vy, p, q, cmag, vv, cc, lhs;
			bit                 negp, negq, cneg;
			bit [31:0]          qv, cand;
			bit [63:0]          t;
			corr_result_t       r;

			el = lag_reg;
			if (el > MAX_LAG_TB) el = MAX_LAG_TB;
			if (el < -MAX_LAG_TB) el = -MAX_LAG_TB;

			// pairing and delay store
			if (sample_idx >= MAX_SAMPLES) begin
				ovf = 1;
			end else begin
				d = (el < 0) ? -el : el;
				if (d == 0) begin
					add_pair(x, y);
				end else begin
					old = delay_mem[(sample_idx - d) % MAX_LAG_TB];
					if (el > 0) begin
						if (sample_idx >= d) add_pair(old, y);
						delay_mem[sample_idx % MAX_LAG_TB] = x;
					end else begin
						if (sample_idx >= d) add_pair(x, old);
						delay_mem[sample_idx % MAX_LAG_TB] = y;
					end
				end
				sample_idx++;
			end
			if (!lst) return;

			// exact variance and covariance terms
			m_w = pair_cnt;
			ax = (sx < 0) ? -sx : sx;
			ay = (sy < 0) ? -sy : sy;
			axy = (sxy < 0) ? -sxy : sxy;
			vx = m_w * sxx - ax * ax;
			vy = m_w * syy - ay * ay;
			p = m_w * axy;
			negp = sxy < 0;
			q = ax * ay;
			negq = (sx < 0) != (sy < 0);
			if (negp == negq) begin
				if (p >= q) begin
					cmag = p - q; cneg = negp;
				end else begin
					cmag = q - p; cneg = !negp;
				end
			end else begin
				cmag = p + q; cneg = negp;
			end

			r.corr = 0;
			qv = 0;
			if (pair_cnt == 0) begin
				r.stat = ST_NO_PAIRS;
			end else if (vx == 0 || vy == 0) begin
				r.stat = ST_ZERO_VAR;
			end else begin
				r.stat = ST_OK;
				vv = vx * vy;
				cc = (cmag * cmag) << 32;
				// rounded square root by bit search
				for (int b = 14; b >= 0; b--) begin
					cand = qv | (32'd1 << b);
					t = 2 * cand - 1;
					lhs = t * t;
					lhs = lhs * vv;
					if (lhs <= cc) qv = cand;
				end
				r.corr = cneg ? -qv[15:0] : qv[15:0];
			end
			if (ovf) r.stat = ST_OVERFLOW;
			r.pairs = pair_cnt[16:0];
			expected_q.push_back(r);
			clear();
		endfunction

		task check_result(logic signed [15:0] c, logic [1:0] s, logic [16:0] n);
			corr_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result corr=%0d status=%0d pairs=%0d", c, s, n));
				return;
			end
			e = expected_q.pop_front();
			if (c !== e.corr)
				report($sformatf("correlation %0d, expected %0d", c, e.corr));
			if (s !== e.stat)
				report($sformatf("status %0d, expected %0d", s, e.stat));
			if (n !== e.pairs)
				report($sformatf("pairs_used %0d, expected %0d", n, e.pairs));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic signed [7:0]  lag;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] x_sample;
	logic signed [15:0] y_sample;
	logic               last;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] correlation;
	logic [1:0]         status;
	logic [16:0]        pairs_used;

	corr_scoreboard sb = new();
	int  cycles = 0;
	int  burst_left = 0;
	bit  hold_req = 0;
	int  items_sent = 0;

	lagged_pearson_correlation dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.lag         (lag),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_sample    (x_sample),
		.y_sample    (y_sample),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.correlation (correlation),
		.status      (status),
		.pairs_used  (pairs_used)
	);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stall pattern, with an occasional long hold-off
	initial begin
		int stretch;
		int mode;
		int hold_left;
		stretch = 0;
		mode = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 0;
			end
			if (stretch == 0) begin
				stretch = $urandom_range(5, 80);
				mode = $urandom_range(0, 3);
			end
			stretch--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// output transfers
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(correlation, status, pairs_used);
	end

	// one input transfer, with random bursts and gaps
	task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic lst);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		x_sample <= x;
		y_sample <= y;
		last <= lst;
		do @(posedge clk); while (in_stall);
		sb.note_input(x, y, lst);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// lag write, only with the block idle
	task automatic write_lag(logic signed [7:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		lag <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_lag(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom());
		endcase
	endfunction

	// one series; y follows x in several ways so that r spans its range
	task automatic send_series(int len);
		int                 ymode;
		logic signed [15:0] x, y, c;
		ymode = $urandom_range(0, 5);
		c = pick_sample();
		for (int i = 0; i < len; i++) begin
			x = pick_sample();
			case (ymode)
				0: y = x;
				1: y = -x;
				2: y = x + $signed(16'($urandom_range(0, 2047)) - 16'sd1024);
				3: y = c;
				4: y = (x >>> 1) - $signed(16'($urandom_range(0, 8191)));
				default: y = pick_sample();
			endcase
			send_pair(x, y, i == len - 1);
		end
	endtask

	initial begin
		logic signed [7:0] lag_set[10];
		int                per_phase;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		lag = '0;
		in_valid = 1'b0;
		x_sample = '0;
		y_sample = '0;
		last = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corner series
		write_lag(8'sd0);
		send_pair(16'sh7fff, 16'sh7fff, 0);
		send_pair(16'sh8000, 16'sh8000, 1);
		send_pair(16'sd5, 16'sd7, 1);
		send_pair(16'sd100, 16'sd1, 0);
		send_pair(16'sd100, 16'sd2, 0);
		send_pair(16'sd100, 16'sd3, 1);
		send_pair(16'sd1, -16'sd1, 0);
		send_pair(16'sd2, -16'sd2, 0);
		send_pair(16'sd3, -16'sd3, 1);
		send_pair(16'sh8000, 16'sh7fff, 0);
		send_pair(16'sh7fff, 16'sh8000, 0);
		send_pair(16'sd0, 16'sd0, 1);
		// lag longer than the series: no pairs
		write_lag(8'sd5);
		send_pair(16'sd1, 16'sd2, 0);
		send_pair(16'sd3, 16'sd4, 0);
		send_pair(16'sd5, 16'sd6, 1);
		write_lag(-8'sd3);
		send_pair(16'sd10, 16'sd1, 0);
		send_pair(16'sd20, 16'sd5, 0);
		send_pair(16'sd30, 16'sd2, 0);
		send_pair(16'sd40, 16'sd9, 0);
		send_pair(16'sd55, 16'sd3, 1);

		// random series over several lags, extremes and clamped values included
		lag_set = '{8'sd0, 8'sd64, -8'sd64, 8'sd127, 8'sh80, 8'sd1, -8'sd1,
			8'sd17, -8'sd33, 8'sd0};
		lag_set[9] = 8'($urandom_range(0, 255));
		per_phase = RAND_ITEMS / 10;
		foreach (lag_set[k]) begin
			write_lag(lag_set[k]);
			items_sent = 0;
			while (items_sent < per_phase) begin
				if ($urandom_range(0, 4) == 0)
					send_series($urandom_range(1, 4));
				else if ($urandom_range(0, 5) == 0)
					send_series($urandom_range(60, 140));
				else
					send_series($urandom_range(5, 40));
			end
		end

		// long receiver hold-off while short series keep coming
		write_lag(8'sd0);
		hold_req = 1;
		for (int i = 0; i < 12; i++)
			send_series($urandom_range(1, 3));
		drain();

		send_series(6);

		drain();
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/lpc_pkg.sv
src/lpc_accum.sv
src/lpc_mul.sv
src/lpc_datapath.sv
src/lpc_ctrl.sv
src/lagged_pearson_correlation.sv
test/tb.sv
